@@ rtl/cto_pkg.sv @@
// Shared constants, types and cosine table generation for the cosine table oscillator.
package cto_pkg;

    localparam int TABLE_SIZE  = 512;
    localparam int SAMPLE_BITS = 16;
    localparam int SAMPLE_OUT  = 16;
    localparam int PHASE_BITS  = 32;
    localparam int FREQ_BITS   = 32;
    localparam int PV_BITS     = 16;

    localparam int IDX_BITS    = $clog2(TABLE_SIZE);
    localparam int FRAC_BITS   = PHASE_BITS - IDX_BITS;
    localparam int ADDR_BITS   = $clog2(TABLE_SIZE + 1);
    localparam int QTR_BITS    = IDX_BITS - 2;
    localparam int QUARTER     = TABLE_SIZE / 4;
    localparam int MAG_BITS    = SAMPLE_BITS - 1;
    localparam int INC_SHIFT   = 12 + IDX_BITS;
    localparam int TERM_BITS   = SAMPLE_BITS + 2;
    localparam int PROD_BITS   = SAMPLE_BITS + FRAC_BITS + 2;
    localparam int OUT_SHR     = (SAMPLE_BITS >= SAMPLE_OUT) ? SAMPLE_BITS - SAMPLE_OUT : 0;
    localparam int OUT_SHL     = (SAMPLE_BITS < SAMPLE_OUT) ? SAMPLE_OUT - SAMPLE_BITS : 0;
    localparam int WIDE_BITS   = SAMPLE_BITS + SAMPLE_OUT;

    localparam int OUTQ_DEPTH  = 4;
    localparam int OUTQ_PTR    = $clog2(OUTQ_DEPTH);
    localparam int CREDIT_BITS = $clog2(OUTQ_DEPTH + 1);

    localparam logic [PHASE_BITS-1:0] STEPS_RESET = 32'd47721859;
    localparam logic [63:0]           PI_Q30      = 64'd3373259426;

    // item function codes
    localparam logic FUNC_SAMPLE    = 1'b0;
    localparam logic FUNC_SET_PHASE = 1'b1;

    // quadrants in which the table value is negated
    localparam logic [1:0] QUAD_SECOND = 2'd1;
    localparam logic [1:0] QUAD_THIRD  = 2'd2;

    typedef logic [QUARTER-1:0][MAG_BITS-1:0] t_quarter;

    typedef struct packed {
        logic                   we;
        logic [ADDR_BITS-1:0]   addr;
        logic [SAMPLE_BITS-1:0] data;
    } t_ram_wr;

    typedef struct packed {
        logic                 valid;
        logic [ADDR_BITS-1:0] addr_lo;
        logic [ADDR_BITS-1:0] addr_hi;
        logic [FRAC_BITS-1:0] frac;
    } t_lookup;

    // one Taylor step: divide by the term's factorial ratio
    function automatic logic [63:0] series_div(logic [63:0] x, int k, logic want_sin);
        logic [63:0] q;
        q = '0;
        if (want_sin) begin
            case (k)
                1:       q = x / 6;
                2:       q = x / 20;
                3:       q = x / 42;
                4:       q = x / 72;
                5:       q = x / 110;
                6:       q = x / 156;
                7:       q = x / 210;
                8:       q = x / 272;
                9:       q = x / 342;
                default: q = '0;
            endcase
        end else begin
            case (k)
                1:       q = x / 2;
                2:       q = x / 12;
                3:       q = x / 30;
                4:       q = x / 56;
                5:       q = x / 90;
                6:       q = x / 132;
                7:       q = x / 182;
                8:       q = x / 240;
                9:       q = x / 306;
                default: q = '0;
            endcase
        end
        return q;
    endfunction

    // Q30 series of cos or sin for an angle in the first quadrant
    function automatic logic [63:0] series(logic [63:0] theta, logic want_sin);
        logic [63:0]        t2;
        logic [63:0]        term;
        logic signed [63:0] sum;
        t2   = (theta * theta) >> 30;
        term = want_sin ? theta : (64'd1 << 30);
        sum  = signed'(term);
        for (int k = 1; k <= 9; k++) begin
            term = series_div((term * t2) >> 30, k, want_sin);
            if ((k & 1) != 0)
                sum = sum - signed'(term);
            else
                sum = sum + signed'(term);
        end
        return (sum < 0) ? 64'd0 : unsigned'(sum);
    endfunction

    // magnitudes for one quadrant, rounded half up and saturated
    function automatic t_quarter build_quarter(logic want_sin);
        t_quarter    q;
        logic [63:0] theta;
        logic [63:0] mag;
        logic [63:0] v;
        logic [63:0] maxv;
        maxv = (64'd1 << MAG_BITS) - 64'd1;
        for (int r = 0; r < QUARTER; r++) begin
            theta = (64'd2 * PI_Q30 * 64'(r)) / TABLE_SIZE;
            mag   = series(theta, want_sin);
            v     = ((mag << MAG_BITS) + (64'd1 << 29)) >> 30;
            if (v > maxv)
                v = maxv;
            q[r] = v[MAG_BITS-1:0];
        end
        return q;
    endfunction

    localparam t_quarter COS_QTR = build_quarter(1'b0);
    localparam t_quarter SIN_QTR = build_quarter(1'b1);

endpackage

@@ rtl/cto_ram.sv @@
// Generic single-write, dual-read synchronous RAM with registered read data.
module cto_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 513
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_a,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_b,
    output logic [WIDTH-1:0]         o_rdata_a,
    output logic [WIDTH-1:0]         o_rdata_b
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we)
            r_mem[i_waddr] <= i_wdata;
        o_rdata_a <= r_mem[i_raddr_a];
        o_rdata_b <= r_mem[i_raddr_b];
    end

endmodule

@@ rtl/cto_fill.sv @@
// Post-reset sweep that writes the cosine table into the RAM from quarter-wave constants.
module cto_fill
    import cto_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    output logic    o_busy,
    output t_ram_wr o_wr
);

    logic                 r_busy;
    logic [ADDR_BITS-1:0] r_cnt;
    logic [IDX_BITS-1:0]  j;
    logic [1:0]           quad;
    logic [QTR_BITS-1:0]  r;
    logic [MAG_BITS-1:0]  mag;
    logic                 neg;
    logic [SAMPLE_BITS-1:0] mag_ext;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b1;
            r_cnt  <= '0;
        end else if (r_busy) begin
            if (r_cnt == ADDR_BITS'(TABLE_SIZE))
                r_busy <= 1'b0;
            r_cnt <= r_cnt + 1'b1;
        end
    end

    always_comb begin
        j       = r_cnt[IDX_BITS-1:0];
        quad    = j[IDX_BITS-1:IDX_BITS-2];
        r       = j[QTR_BITS-1:0];
        // odd quadrants take the sine of the reduced angle
        mag     = quad[0] ? SIN_QTR[r] : COS_QTR[r];
        neg     = (quad == QUAD_SECOND) || (quad == QUAD_THIRD);
        mag_ext = {1'b0, mag};
        o_wr.we   = r_busy;
        o_wr.addr = r_cnt;
        o_wr.data = neg ? (~mag_ext + 1'b1) : mag_ext;
    end

    assign o_busy = r_busy;

endmodule

@@ rtl/cto_phase.sv @@
// Phase accumulator with registered increment multiplier and table address generation.
module cto_phase
    import cto_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_accept,
    input  logic                  i_func,
    input  logic [FREQ_BITS-1:0]  i_frequency,
    input  logic [PV_BITS-1:0]    i_phase_value,
    input  logic                  i_cfg_we,
    input  logic [PHASE_BITS-1:0] i_cfg_data,
    output t_lookup               o_lookup
);

    logic [PHASE_BITS-1:0]       r_acc;
    logic [PHASE_BITS-1:0]       r_inc;
    logic [PHASE_BITS-1:0]       r_steps;
    logic [PHASE_BITS-1:0]       cur;
    logic [PHASE_BITS-1:0]       n_acc;
    logic [PHASE_BITS-1:0]       n_inc;
    logic signed [FREQ_BITS+PHASE_BITS:0] prod;
    logic [IDX_BITS-1:0]         idx;
    logic                        take_sample;

    // the registered increment folds in on the next cycle; cur is the true phase
    assign cur         = r_acc + r_inc;
    assign take_sample = i_accept && (i_func == FUNC_SAMPLE);

    always_comb begin
        prod = (FREQ_BITS+PHASE_BITS+1)'($signed(i_frequency))
             * (FREQ_BITS+PHASE_BITS+1)'($signed({1'b0, r_steps}));
        n_acc = cur;
        n_inc = '0;
        if (i_accept && (i_func == FUNC_SET_PHASE)) begin
            n_acc = {i_phase_value, {(PHASE_BITS-PV_BITS){1'b0}}};
        end else if (take_sample) begin
            n_inc = prod[INC_SHIFT+PHASE_BITS-1:INC_SHIFT];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc   <= '0;
            r_inc   <= '0;
            r_steps <= STEPS_RESET;
        end else begin
            r_acc <= n_acc;
            r_inc <= n_inc;
            if (i_cfg_we)
                r_steps <= i_cfg_data;
        end
    end

    always_comb begin
        idx              = cur[PHASE_BITS-1:FRAC_BITS];
        o_lookup.valid   = take_sample;
        o_lookup.addr_lo = ADDR_BITS'(idx);
        o_lookup.addr_hi = ADDR_BITS'(idx) + 1'b1;
        o_lookup.frac    = cur[FRAC_BITS-1:0];
    end

endmodule

@@ rtl/cto_interp.sv @@
// Two-stage linear interpolation between adjacent table entries.
module cto_interp
    import cto_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  t_lookup                i_lookup,
    input  logic [SAMPLE_BITS-1:0] i_rdata_lo,
    input  logic [SAMPLE_BITS-1:0] i_rdata_hi,
    output logic                   o_valid,
    output logic [SAMPLE_OUT-1:0]  o_sample
);

    logic                         r_s1_valid;
    logic [FRAC_BITS-1:0]         r_s1_frac;
    logic                         r_s2_valid;
    logic signed [SAMPLE_BITS-1:0] r_s2_f1;
    logic signed [TERM_BITS-1:0]  r_s2_term;

    logic signed [SAMPLE_BITS:0]  diff;
    logic signed [PROD_BITS-1:0]  prod;
    logic signed [TERM_BITS-1:0]  y;
    logic signed [WIDE_BITS-1:0]  wide;

    always_comb begin
        diff = $signed({i_rdata_hi[SAMPLE_BITS-1], i_rdata_hi})
             - $signed({i_rdata_lo[SAMPLE_BITS-1], i_rdata_lo});
        prod = PROD_BITS'(diff) * PROD_BITS'($signed({1'b0, r_s1_frac}));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
        end else begin
            r_s1_valid <= i_lookup.valid;
            r_s2_valid <= r_s1_valid;
        end
        r_s1_frac <= i_lookup.frac;
        r_s2_f1   <= $signed(i_rdata_lo);
        // floor of the product by the fraction width: plain bit select
        r_s2_term <= prod[FRAC_BITS+TERM_BITS-1:FRAC_BITS];
    end

    always_comb begin
        y    = TERM_BITS'(r_s2_f1) + r_s2_term;
        wide = WIDE_BITS'(y) <<< OUT_SHL;
    end

    assign o_valid  = r_s2_valid;
    assign o_sample = wide[OUT_SHR+SAMPLE_OUT-1:OUT_SHR];

endmodule

@@ rtl/cto_outq.sv @@
// Output queue with credit count covering samples still in the pipeline.
module cto_outq
    import cto_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_reserve,
    input  logic                  i_wr,
    input  logic [SAMPLE_OUT-1:0] i_wdata,
    input  logic                  i_stall,
    output logic                  o_full,
    output logic                  o_valid,
    output logic [SAMPLE_OUT-1:0] o_sample
);

    logic [SAMPLE_OUT-1:0]  r_mem [OUTQ_DEPTH];
    logic [OUTQ_PTR-1:0]    r_wr_ptr;
    logic [OUTQ_PTR-1:0]    r_rd_ptr;
    logic [CREDIT_BITS-1:0] r_count;
    logic [CREDIT_BITS-1:0] r_credit;
    logic                   pop;

    assign o_valid  = (r_count != '0);
    assign o_sample = r_mem[r_rd_ptr];
    assign pop      = o_valid && !i_stall;
    // credit spans accepted samples not yet taken, so the queue never overflows
    assign o_full   = (r_credit == CREDIT_BITS'(OUTQ_DEPTH));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
            r_credit <= '0;
        end else begin
            if (i_wr)
                r_wr_ptr <= r_wr_ptr + 1'b1;
            if (pop)
                r_rd_ptr <= r_rd_ptr + 1'b1;
            r_count  <= r_count + CREDIT_BITS'(i_wr) - CREDIT_BITS'(pop);
            r_credit <= r_credit + CREDIT_BITS'(i_reserve) - CREDIT_BITS'(pop);
        end
        if (i_wr)
            r_mem[r_wr_ptr] <= i_wdata;
    end

endmodule

@@ rtl/cosine_table_oscillator.sv @@
// Top level of the cosine table oscillator.
//
// Input channel (i_valid / o_stall): one beat per item. i_func selects a
// sample item, which emits one interpolated cosine sample and then advances
// the phase by i_frequency times steps_per_hz, or a set-phase item, which
// loads the phase from i_phase_value and emits nothing.
// Output channel (o_valid / i_stall): one beat per sample, o_sample in Q1.15.
// Config channel (i_cfg_valid / o_cfg_ready): writes steps_per_hz, Q0.32.
// Ready is always high; write only while the block is idle.
// Throughput: one item per cycle while o_stall is low, set by the phase
// add and the two read ports of the table RAM feeding the interpolation
// pipeline. A sample passes the RAM read, interpolation and queue registers.
// Reset: the phase clears and steps_per_hz returns to its default; the table
// RAM is then filled with all 513 entries, during which o_stall is high.
// Stall: a four-entry output queue with credit absorbs the pipeline; with
// the receiver stalled, up to four samples are accepted, then o_stall rises.
module cosine_table_oscillator
    import cto_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_stall,
    input  logic                  i_func,
    input  logic [FREQ_BITS-1:0]  i_frequency,
    input  logic [PV_BITS-1:0]    i_phase_value,
    output logic                  o_valid,
    input  logic                  i_stall,
    output logic [SAMPLE_OUT-1:0] o_sample,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [PHASE_BITS-1:0] i_cfg_data
);

    logic                   fill_busy;
    t_ram_wr                fill_wr;
    t_lookup                lookup;
    logic                   accept;
    logic                   q_full;
    logic [SAMPLE_BITS-1:0] rdata_lo;
    logic [SAMPLE_BITS-1:0] rdata_hi;
    logic                   res_valid;
    logic [SAMPLE_OUT-1:0]  res_sample;

    assign o_cfg_ready = 1'b1;
    assign o_stall     = fill_busy || q_full;
    assign accept      = i_valid && !o_stall;

    cto_fill u_fill (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .o_busy  (fill_busy),
        .o_wr    (fill_wr)
    );

    cto_phase u_phase (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_accept      (accept),
        .i_func        (i_func),
        .i_frequency   (i_frequency),
        .i_phase_value (i_phase_value),
        .i_cfg_we      (i_cfg_valid),
        .i_cfg_data    (i_cfg_data),
        .o_lookup      (lookup)
    );

    cto_ram #(
        .WIDTH (SAMPLE_BITS),
        .DEPTH (TABLE_SIZE + 1)
    ) u_table (
        .i_clk     (i_clk),
        .i_we      (fill_wr.we),
        .i_waddr   (fill_wr.addr),
        .i_wdata   (fill_wr.data),
        .i_raddr_a (lookup.addr_lo),
        .i_raddr_b (lookup.addr_hi),
        .o_rdata_a (rdata_lo),
        .o_rdata_b (rdata_hi)
    );

    cto_interp u_interp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_lookup   (lookup),
        .i_rdata_lo (rdata_lo),
        .i_rdata_hi (rdata_hi),
        .o_valid    (res_valid),
        .o_sample   (res_sample)
    );

    cto_outq u_outq (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_reserve (lookup.valid),
        .i_wr      (res_valid),
        .i_wdata   (res_sample),
        .i_stall   (i_stall),
        .o_full    (q_full),
        .o_valid   (o_valid),
        .o_sample  (o_sample)
    );

endmodule

@@ rtl/cto_checker.sv @@
// Port-level checker for the cosine table oscillator, bound to the top level.
module cto_checker
    import cto_pkg::*;
(
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  i_valid,
    input logic                  o_stall,
    input logic                  i_func,
    input logic                  o_valid,
    input logic                  i_stall,
    input logic [SAMPLE_OUT-1:0] o_sample
);

    // reset empties the output and holds off input while the table fills
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> o_stall && !o_valid)
        else $error("output not quiet after reset");

    // a sample beat has produced its result once through the pipeline
    a_sample_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall && (i_func == FUNC_SAMPLE) |-> ##3 o_valid)
        else $error("sample missing three cycles after its input beat");

    a_out_hold_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid)
        else $error("output valid dropped while stalled");

    a_out_hold_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> $stable(o_sample))
        else $error("output sample changed while stalled");

endmodule

bind cosine_table_oscillator cto_checker u_cto_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .i_valid  (i_valid),
    .o_stall  (o_stall),
    .i_func   (i_func),
    .o_valid  (o_valid),
    .i_stall  (i_stall),
    .o_sample (o_sample)
);

@@ bench/testbench.sv @@
// Self-checking testbench for the cosine table oscillator.
`timescale 1ns / 100ps

module testbench
    import cto_pkg::*;
();

    localparam int CLK_HALF     = 2;
    localparam int RESET_CYCLES = 11;
    localparam int PIPE_TAIL    = 8;
    localparam int HOLD_CYCLES  = 60;
    localparam int DRAIN_LIMIT  = 2000;
    localparam int TIMEOUT_NS   = 1_000_000;
    localparam int RANDOM_ITEMS = 110;

    typedef enum logic [1:0] {RX_NEVER, RX_RANDOM, RX_PATTERN, RX_HEAVY} t_rx_mode;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_valid;
    logic                  o_stall;
    logic                  i_func;
    logic [FREQ_BITS-1:0]  i_frequency;
    logic [PV_BITS-1:0]    i_phase_value;
    logic                  o_valid;
    logic                  i_stall;
    logic [SAMPLE_OUT-1:0] o_sample;
    logic                  i_cfg_valid;
    logic                  o_cfg_ready;
    logic [PHASE_BITS-1:0] i_cfg_data;

    // predictor state
    int                    cos_table [0:TABLE_SIZE];
    logic [PHASE_BITS-1:0] shadow_phase;
    logic [PHASE_BITS-1:0] shadow_steps;
    logic [SAMPLE_OUT-1:0] expected_samples [$];

    int unsigned error_count;
    t_rx_mode    rx_mode;
    logic        hold_request;

    cosine_table_oscillator DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_func        (i_func),
        .i_frequency   (i_frequency),
        .i_phase_value (i_phase_value),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_sample      (o_sample),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data)
    );

    always #(CLK_HALF) i_clk = ~i_clk;

    // Q30 Taylor series, cosine or sine, angle within the first quadrant
    function automatic longint unsigned taylor_q30(longint unsigned theta, logic odd);
        longint unsigned sq;
        longint unsigned term;
        longint unsigned div;
        longint          acc;
        sq   = (theta * theta) >> 30;
        term = odd ? theta : (64'd1 << 30);
        acc  = longint'(term);
        for (int k = 1; k <= 9; k++) begin
            div  = odd ? 64'((2 * k) * (2 * k + 1)) : 64'((2 * k - 1) * (2 * k));
            term = ((term * sq) >> 30) / div;
            if ((k % 2) != 0)
                acc = acc - longint'(term);
            else
                acc = acc + longint'(term);
        end
        return (acc < 0) ? 64'd0 : longint'(acc);
    endfunction

    function automatic void fill_cos_table();
        int              j;
        int              r;
        logic [1:0]      quad;
        longint unsigned theta;
        longint unsigned mag;
        longint unsigned v;
        longint unsigned vmax;
        vmax = (64'd1 << (SAMPLE_BITS - 1)) - 64'd1;
        for (int i = 0; i <= TABLE_SIZE; i++) begin
            j     = i & (TABLE_SIZE - 1);
            quad  = 2'((j / QUARTER) & 3);
            r     = j % QUARTER;
            theta = (64'd2 * PI_Q30 * 64'(r)) / 64'(TABLE_SIZE);
            mag   = taylor_q30(theta, quad[0]);
            v     = ((mag << (SAMPLE_BITS - 1)) + (64'd1 << 29)) >> 30;
            if (v > vmax)
                v = vmax;
            cos_table[i] = (quad == QUAD_SECOND || quad == QUAD_THIRD) ? -int'(v) : int'(v);
        end
    endfunction

    // advance the shadow oscillator by one accepted beat
    function automatic void oscillate(logic func, logic [FREQ_BITS-1:0] freq,
                                      logic [PV_BITS-1:0] pv);
        logic [IDX_BITS-1:0]  idx;
        logic [FRAC_BITS-1:0] frac;
        longint               lo;
        longint               hi;
        longint               y;
        longint               prod;
        if (func == FUNC_SET_PHASE) begin
            shadow_phase = {pv, 16'd0};
        end else begin
            idx  = shadow_phase[PHASE_BITS-1 -: IDX_BITS];
            frac = shadow_phase[FRAC_BITS-1:0];
            lo   = cos_table[int'(idx)];
            hi   = cos_table[int'(idx) + 1];
            y    = lo + (((hi - lo) * longint'(frac)) >>> FRAC_BITS);
            if (SAMPLE_BITS >= SAMPLE_OUT)
                y = y >>> (SAMPLE_BITS - SAMPLE_OUT);
            else
                y = y <<< (SAMPLE_OUT - SAMPLE_BITS);
            expected_samples.push_back(y[SAMPLE_OUT-1:0]);
            // exact product, floored to the phase fraction; the add wraps
            prod = longint'(signed'(freq)) * longint'({32'd0, shadow_steps});
            shadow_phase = shadow_phase + prod[INC_SHIFT +: PHASE_BITS];
        end
    endfunction

    function automatic logic [FREQ_BITS-1:0] pick_frequency();
        logic [FREQ_BITS-1:0] f;
        case ($urandom_range(0, 3))
            0:       f = $urandom;
            3:       f = $urandom_range(0, 255);
            default: f = $urandom_range(0, 24000 << 12);
        endcase
        if ($urandom_range(0, 1) != 0)
            f = -f;
        return f;
    endfunction

    task automatic send_item(input logic func, input logic [FREQ_BITS-1:0] freq,
                             input logic [PV_BITS-1:0] pv);
        @(negedge i_clk);
        i_valid       <= 1'b1;
        i_func        <= func;
        i_frequency   <= freq;
        i_phase_value <= pv;
        @(posedge i_clk);
        while (o_stall)
            @(posedge i_clk);
        oscillate(func, freq, pv);
    endtask

    task automatic idle_gap(input int cycles);
        if (cycles > 0) begin
            @(negedge i_clk);
            i_valid <= 1'b0;
            repeat (cycles - 1) @(negedge i_clk);
            @(posedge i_clk);
        end
    endtask

    task automatic write_steps(input logic [PHASE_BITS-1:0] value);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        @(posedge i_clk);
        while (!o_cfg_ready)
            @(posedge i_clk);
        shadow_steps = value;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // set-phase beats leave no result behind, so allow the pipe to empty too
    task automatic wait_quiet();
        while (expected_samples.size() != 0)
            @(posedge i_clk);
        repeat (PIPE_TAIL) @(posedge i_clk);
    endtask

    task automatic send_random_items(input int count, input logic bursty);
        int   burst_left;
        logic func;
        burst_left = 0;
        for (int n = 0; n < count; n++) begin
            if (bursty && burst_left == 0) begin
                idle_gap($urandom_range(0, 6));
                burst_left = $urandom_range(1, 12);
            end
            if (bursty)
                burst_left--;
            func = ($urandom_range(0, 7) == 0) ? FUNC_SET_PHASE : FUNC_SAMPLE;
            send_item(func, pick_frequency(), PV_BITS'($urandom));
        end
        idle_gap(1);
    endtask

    task automatic test_directed_corners();
        rx_mode = RX_NEVER;
        send_item(FUNC_SAMPLE, 32'd0, 16'hFFFF);          // phase zero: table peak
        send_item(FUNC_SET_PHASE, 32'hFFFF_FFFF, 16'hFFFF);
        send_item(FUNC_SAMPLE, 32'h7FFF_FFFF, 16'h0000);  // last segment before wrap
        send_item(FUNC_SAMPLE, 32'h8000_0000, 16'h0000);
        send_item(FUNC_SAMPLE, 32'hFFFF_FFFF, 16'hFFFF);
        send_item(FUNC_SAMPLE, 32'h0000_0001, 16'h0000);
        send_item(FUNC_SET_PHASE, 32'd0, 16'h4000);
        send_item(FUNC_SAMPLE, 32'd0, 16'h0000);
        send_item(FUNC_SET_PHASE, 32'd0, 16'h8000);
        send_item(FUNC_SAMPLE, 32'd0, 16'h0000);
        send_item(FUNC_SET_PHASE, 32'd0, 16'hC000);
        send_item(FUNC_SAMPLE, 32'd0, 16'h0000);
        send_item(FUNC_SET_PHASE, 32'd0, 16'h0001);       // smallest nonzero phase value
        send_item(FUNC_SAMPLE, 32'd0, 16'h0000);
        send_item(FUNC_SET_PHASE, 32'h8000_0000, 16'h0000);
        send_item(FUNC_SAMPLE, 32'h0000_1000, 16'h0000);  // 1 Hz
        send_item(FUNC_SAMPLE, 32'd98_304_000, 16'h0000); // 24 kHz
        send_item(FUNC_SAMPLE, -32'sd98_304_000, 16'h0000);
        send_item(FUNC_SET_PHASE, 32'd0, 16'h7FFF);
        send_item(FUNC_SAMPLE, 32'd0, 16'h0000);
        idle_gap(1);
        wait_quiet();
    endtask

    // receiver holds off while beats keep coming, so the block must stall its input
    task automatic test_output_backpressure();
        rx_mode      = RX_NEVER;
        hold_request = 1'b1;
        for (int n = 0; n < 24; n++)
            send_item(FUNC_SAMPLE, pick_frequency(), PV_BITS'($urandom));
        idle_gap(1);
        wait_quiet();
    endtask

    task automatic test_steps_settings();
        logic [PHASE_BITS-1:0] steps;
        for (int k = 0; k < 6; k++) begin
            case (k)
                0:       steps = '0;
                1:       steps = '1;
                2:       steps = 32'd1;
                3:       steps = 32'h8000_0000;
                4:       steps = $urandom;
                default: steps = STEPS_RESET;
            endcase
            wait_quiet();
            write_steps(steps);
            rx_mode = t_rx_mode'($urandom_range(0, 3));
            send_random_items(25, 1'b1);
        end
        wait_quiet();
    endtask

    task automatic test_random_traffic();
        longint unsigned rate;
        for (int seg = 0; seg < 5; seg++) begin
            wait_quiet();
            rate = $urandom_range(8000, 192000);
            write_steps(PHASE_BITS'(((64'd1 << 32) * 64'(TABLE_SIZE)) / rate));
            rx_mode = t_rx_mode'(seg % 4);
            send_random_items(RANDOM_ITEMS, seg != 3);
        end
        wait_quiet();
    endtask

    // receiver stall pattern, driven on the falling edge
    initial begin : rx_stall_gen
        int rx_tick;
        rx_tick = 0;
        forever begin
            @(negedge i_clk);
            rx_tick++;
            if (hold_request) begin
                hold_request = 1'b0;
                i_stall <= 1'b1;
                for (int held = 1; held < HOLD_CYCLES; held++)
                    @(negedge i_clk);
            end else begin
                case (rx_mode)
                    RX_RANDOM:  i_stall <= ($urandom_range(0, 99) < 30);
                    RX_PATTERN: i_stall <= ((rx_tick % 9) < 3);
                    RX_HEAVY:   i_stall <= ($urandom_range(0, 99) < 70);
                    default:    i_stall <= 1'b0;
                endcase
            end
        end
    end

    // each sample beat against the oldest outstanding prediction
    always @(posedge i_clk) begin : sample_check
        logic [SAMPLE_OUT-1:0] want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (expected_samples.size() == 0) begin
                $display("%0t: sample %0d with nothing outstanding", $time, $signed(o_sample));
                error_count++;
            end else begin
                want = expected_samples.pop_front();
                if (o_sample !== want) begin
                    $display("%0t: sample expected %0d got %0d", $time,
                             $signed(want), $signed(o_sample));
                    error_count++;
                end
            end
        end
    end

    initial begin
        #(TIMEOUT_NS);
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial begin
        i_clk         = 1'b0;
        i_rst_n       = 1'b0;
        i_valid       = 1'b0;
        i_func        = FUNC_SAMPLE;
        i_frequency   = '0;
        i_phase_value = '0;
        i_stall       = 1'b0;
        i_cfg_valid   = 1'b0;
        i_cfg_data    = '0;
        error_count   = 0;
        rx_mode       = RX_NEVER;
        hold_request  = 1'b0;
        shadow_phase  = '0;
        shadow_steps  = STEPS_RESET;
        fill_cos_table();

        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed_corners();
        test_output_backpressure();
        test_steps_settings();
        test_random_traffic();

        for (int n = 0; n < DRAIN_LIMIT && expected_samples.size() != 0; n++)
            @(posedge i_clk);
        repeat (PIPE_TAIL) @(posedge i_clk);
        if (expected_samples.size() != 0) begin
            $display("%0t: %0d samples never arrived, oldest %0d", $time,
                     expected_samples.size(), $signed(expected_samples[0]));
            error_count += expected_samples.size();
        end

        if (error_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

@@ sim.f @@
rtl/cto_pkg.sv
rtl/cto_ram.sv
rtl/cto_fill.sv
rtl/cto_phase.sv
rtl/cto_interp.sv
rtl/cto_outq.sv
rtl/cosine_table_oscillator.sv
rtl/cto_checker.sv
bench/testbench.sv
